/* rtl/dqkc_pkg.sv */
// Package with the shared constants, codes and word layouts of the dual queue key collator.
`timescale 1ns / 1ps
`default_nettype none

package dqkc_pkg;

  localparam int DEPTH_DEFAULT  = 16;
  localparam int HANDLE_DEFAULT = 16;

  localparam int KEY_W     = 64;
  localparam int HANDLE_W  = 16;
  localparam int LIMIT_W   = 5;
  localparam int EVICT_W   = 5;
  localparam int DISCARD_W = 32;
  localparam int STATUS_W  = 3;
  localparam int IN_USER_W = 3;
  localparam int IN_DATA_W = 80;
  localparam int OUT_DATA_W = 136;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd17;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_ADDED   = 3'd0,
    STATUS_DUP     = 3'd1,
    STATUS_BAD_Q   = 3'd2,
    STATUS_MATCHED = 3'd3,
    STATUS_NONE    = 3'd4
  } status_t;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_MATCH = 1'b1;

endpackage

`default_nettype wire

/* rtl/dual_queue_key_collator.sv */
// Dual queue key collator: two key-ordered circular stores with a shared key comparator.
// An add scans to the insert slot, shifts the entries above it when it inserts, then runs the
// eviction pass and a result load. A match runs the merge walk over both stores, then a result load.
// One word at a time goes through one 64-bit signed comparator; the next word is accepted once
// the result is loaded, and a stalled output holds the block in its result state.
// Reset (rst, synchronous) empties both stores, clears the discard count and sets the limit to 17.
`timescale 1ns / 1ps
`default_nettype none

module dual_queue_key_collator
  import dqkc_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEPTH_DEFAULT,
  parameter int HANDLE_BITS = HANDLE_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_wr_en,
  input  wire logic [LIMIT_W-1:0]     cfg_wr_data,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // Fields from bit 0: pulse_key[63:0], payload_handle[79:64].
  input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,
  // Fields from bit 0: command[0], queue_select[2:1].
  input  wire logic [IN_USER_W-1:0]   s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // Fields from bit 0: evicted_now[4:0], matched_key[68:5], first_handle[84:69],
  // second_handle[100:85], discard_total[132:101], zero padding[135:133].
  output logic [OUT_DATA_W-1:0]       m_axis_tdata,
  // Fields from bit 0: status[2:0].
  output logic [STATUS_W-1:0]         m_axis_tuser
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int EW = $clog2(QUEUE_DEPTH + 2);
  localparam int HW = HANDLE_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_SHIFT,
    ST_EVICT,
    ST_MATCH,
    ST_RESULT
  } state_t;

  state_t state;

  logic [KEY_W-1:0] keys0 [QUEUE_DEPTH];
  logic [HW-1:0]    hnd0  [QUEUE_DEPTH];
  logic [KEY_W-1:0] keys1 [QUEUE_DEPTH];
  logic [HW-1:0]    hnd1  [QUEUE_DEPTH];

  logic [IW-1:0]        head0, head1;
  logic [CW-1:0]        count0, count1;
  logic [DISCARD_W-1:0] discard_count;
  logic [LIMIT_W-1:0]   queue_limit;

  logic                 q_sel;
  logic [KEY_W-1:0]     key_r;
  logic [HW-1:0]        hnd_r;
  logic [CW-1:0]        idx, ptr, pos, mi, mj;
  logic [EVICT_W-1:0]   ev_cnt;
  status_t              res_status;
  logic [KEY_W-1:0]     res_key;
  logic [HW-1:0]        res_h0, res_h1;

  function automatic logic [IW-1:0] wrap(input logic [IW-1:0] h, input logic [CW-1:0] i);
    logic [SW-1:0] sum;
    sum = SW'(h) + SW'(i);
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  function automatic logic [HW-1:0] to_store(input logic [HANDLE_W-1:0] h);
    logic [HW+HANDLE_W-1:0] ext;
    ext = {{HW{1'b0}}, h};
    return ext[HW-1:0];
  endfunction

  function automatic logic [HANDLE_W-1:0] to_port(input logic [HW-1:0] h);
    logic [HW+HANDLE_W-1:0] ext;
    ext = {{HANDLE_W{1'b0}}, h};
    return ext[HANDLE_W-1:0];
  endfunction

  logic [CW-1:0]    ptr_m1, scan_l, rd_l0, rd_l1;
  logic [KEY_W-1:0] rk0, rk1, rk_q;
  logic [HW-1:0]    rh0, rh1, rh_q;
  logic [KEY_W-1:0] cmp_a, cmp_b;
  logic             cmp_lt, cmp_eq;
  logic [CW-1:0]    cnt_q;
  logic [IW-1:0]    head_q;
  logic [EW-1:0]    lim_eff;
  logic             evict_go;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_key;
  logic [HW-1:0]    wr_hnd;
  logic             out_free;
  logic [CW-1:0]    mi_p1, mj_p1;

  assign ptr_m1 = (ptr == '0) ? '0 : ptr - CW'(1);
  assign scan_l = (state == ST_SHIFT) ? ptr_m1 : idx;
  assign rd_l0  = (state == ST_MATCH) ? mi : scan_l;
  assign rd_l1  = (state == ST_MATCH) ? mj : scan_l;

  assign rk0 = keys0[wrap(head0, rd_l0)];
  assign rh0 = hnd0[wrap(head0, rd_l0)];
  assign rk1 = keys1[wrap(head1, rd_l1)];
  assign rh1 = hnd1[wrap(head1, rd_l1)];

  assign rk_q   = q_sel ? rk1 : rk0;
  assign rh_q   = q_sel ? rh1 : rh0;
  assign cnt_q  = q_sel ? count1 : count0;
  assign head_q = q_sel ? head1 : head0;

  assign cmp_a  = (state == ST_MATCH) ? rk0 : rk_q;
  assign cmp_b  = (state == ST_MATCH) ? rk1 : key_r;
  assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);
  assign cmp_eq = cmp_a == cmp_b;

  always_comb begin
    if (int'(queue_limit) > QUEUE_DEPTH) begin
      lim_eff = EW'(QUEUE_DEPTH + 1);
    end else begin
      lim_eff = EW'(queue_limit);
    end
  end

  assign evict_go = (cnt_q != '0) && (EW'(cnt_q) >= lim_eff);

  assign wr_en   = (state == ST_SHIFT);
  assign wr_addr = wrap(head_q, ptr);
  assign wr_key  = (ptr == pos) ? key_r : rk_q;
  assign wr_hnd  = (ptr == pos) ? hnd_r : rh_q;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign mi_p1    = mi + CW'(1);
  assign mj_p1    = mj + CW'(1);

  assign s_axis_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en && !q_sel) begin
      keys0[wr_addr] <= wr_key;
      hnd0[wr_addr]  <= wr_hnd;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && q_sel) begin
      keys1[wr_addr] <= wr_key;
      hnd1[wr_addr]  <= wr_hnd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      head0         <= '0;
      head1         <= '0;
      count0        <= '0;
      count1        <= '0;
      discard_count <= '0;
      queue_limit   <= LIMIT_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        queue_limit <= cfg_wr_data;
      end
      if (m_axis_tvalid && m_axis_tready && (state != ST_RESULT)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            key_r   <= s_axis_tdata[KEY_W-1:0];
            hnd_r   <= to_store(s_axis_tdata[KEY_W +: HANDLE_W]);
            q_sel   <= s_axis_tuser[1];
            idx     <= '0;
            mi      <= '0;
            mj      <= '0;
            ev_cnt  <= '0;
            res_key <= '0;
            res_h0  <= '0;
            res_h1  <= '0;
            if (s_axis_tuser[0] == CMD_MATCH) begin
              state <= ST_MATCH;
            end else if (s_axis_tuser[2]) begin
              res_status <= STATUS_BAD_Q;
              state      <= ST_RESULT;
            end else begin
              state <= ST_FIND;
            end
          end
        end
        ST_FIND: begin
          if ((idx < cnt_q) && cmp_lt) begin
            idx <= idx + CW'(1);
          end else if ((idx < cnt_q) && cmp_eq) begin
            res_status <= STATUS_DUP;
            state      <= ST_EVICT;
          end else begin
            res_status <= STATUS_ADDED;
            if (cnt_q == CW'(QUEUE_DEPTH)) begin
              // A full store always loses its smallest key, which may be the new one.
              ev_cnt <= ev_cnt + EVICT_W'(1);
              if (discard_count != '1) begin
                discard_count <= discard_count + DISCARD_W'(1);
              end
              if (idx == '0) begin
                state <= ST_EVICT;
              end else begin
                if (q_sel) begin
                  head1  <= wrap(head1, CW'(1));
                  count1 <= count1 - CW'(1);
                end else begin
                  head0  <= wrap(head0, CW'(1));
                  count0 <= count0 - CW'(1);
                end
                pos   <= idx - CW'(1);
                ptr   <= cnt_q - CW'(1);
                state <= ST_SHIFT;
              end
            end else begin
              pos   <= idx;
              ptr   <= cnt_q;
              state <= ST_SHIFT;
            end
          end
        end
        ST_SHIFT: begin
          if (ptr == pos) begin
            if (q_sel) begin
              count1 <= count1 + CW'(1);
            end else begin
              count0 <= count0 + CW'(1);
            end
            state <= ST_EVICT;
          end else begin
            ptr <= ptr - CW'(1);
          end
        end
        ST_EVICT: begin
          if (evict_go) begin
            if (q_sel) begin
              head1  <= wrap(head1, CW'(1));
              count1 <= count1 - CW'(1);
            end else begin
              head0  <= wrap(head0, CW'(1));
              count0 <= count0 - CW'(1);
            end
            ev_cnt <= ev_cnt + EVICT_W'(1);
            if (discard_count != '1) begin
              discard_count <= discard_count + DISCARD_W'(1);
            end
          end else begin
            state <= ST_RESULT;
          end
        end
        ST_MATCH: begin
          if ((mi < count0) && (mj < count1)) begin
            if (cmp_eq) begin
              res_status <= STATUS_MATCHED;
              res_key    <= rk0;
              res_h0     <= rh0;
              res_h1     <= rh1;
              head0      <= wrap(head0, mi_p1);
              count0     <= count0 - mi_p1;
              head1      <= wrap(head1, mj_p1);
              count1     <= count1 - mj_p1;
              state      <= ST_RESULT;
            end else if (cmp_lt) begin
              mi <= mi_p1;
            end else begin
              mj <= mj_p1;
            end
          end else begin
            res_status <= STATUS_NONE;
            state      <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= res_status;
            m_axis_tdata  <= {3'b000, discard_count, to_port(res_h1), to_port(res_h0),
                              res_key, ev_cnt};
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count0_bound: assert property (@(posedge clk) disable iff (rst)
    count0 <= CW'(QUEUE_DEPTH))
    else $error("Store zero holds more entries than its depth.");

  a_count1_bound: assert property (@(posedge clk) disable iff (rst)
    count1 <= CW'(QUEUE_DEPTH))
    else $error("Store one holds more entries than its depth.");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT) |-> (ptr >= pos) && (ptr < CW'(QUEUE_DEPTH)))
    else $error("Shift pointer left the insert range.");

  a_discard_monotonic: assert property (@(posedge clk) disable iff (rst)
    !rst |=> discard_count >= $past(discard_count))
    else $error("Discard counter went down.");

  a_result_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT) && out_free |=> m_axis_tvalid && (state == ST_IDLE))
    else $error("A finished result was not presented on the output.");

endmodule

`default_nettype wire
